// ----- rtl/timestamped_position_interpolator_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the timestamped position interpolator.
// Each macro expects clk and rst_n to exist in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMPED_POSITION_INTERPOLATOR_UNIT_ASSERT_SVH
`define TIMESTAMPED_POSITION_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TPI_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("tpi: assertion failed");

// Next-cycle implication.
`define TPI_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("tpi: assertion failed");

`endif

// ----- rtl/tpi_pkg.sv -----
// ---------------------------------------------------------------------------
// tpi_pkg
// Shared types, codes and arithmetic helpers of the position interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  localparam int DEPTH_DEF = 16;

  // Configuration register indexes and reset values.
  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_STALE = 1'b1;
  localparam logic [15:0] DELAY_RST = 16'd6;
  localparam logic [15:0] STALE_RST = 16'd60;

  // Command codes.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_SET     = 3'd2;
  localparam logic [2:0] CMD_RESTART = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Divider operand widths: |num| << 16 over a positive tick span.
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 33;

  // Progress clamp, 2^24.
  localparam logic [DIV_NUM_W-1:0] P_CLAMP = DIV_NUM_W'(1) << 24;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_PUT,
    S_WALK_RD,
    S_WALK_CHK,
    S_COPY_RD,
    S_COPY_CHK,
    S_INTERP,
    S_DIV_WAIT,
    S_MUL_X,
    S_MUL_Y,
    S_BLEND_Y
  } state_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd2147483647;
    lo = -44'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // a + trunc(prod / 65536), saturated.
  function automatic logic signed [31:0] blend_fn(input logic signed [31:0] a,
                                                  input logic signed [58:0] prod);
    logic signed [58:0] adj;
    logic signed [58:0] q;
    adj = prod + ((prod < 0) ? 59'sd65535 : 59'sd0);
    q = adj >>> 16;
    blend_fn = sat32(44'(a) + $signed(q[43:0]));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tpi_ram.sv -----
// ---------------------------------------------------------------------------
// tpi_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tpi_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tpi_div.sv -----
// ---------------------------------------------------------------------------
// tpi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tpi_div
  import tpi_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire [DIV_NUM_W-1:0]   num,
  input  wire [DIV_DEN_W-1:0]   den,
  output logic [DIV_NUM_W-1:0]  quo,
  output logic                  done
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   sh;
  logic                 qbit;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r, num_r[DIV_NUM_W-1]};
    qbit     = (sh >= {1'b0, den_r});
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_NUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = qbit ? DIV_DEN_W'(sh - {1'b0, den_r}) : sh[DIV_DEN_W-1:0];
      num_nxt = {num_r[DIV_NUM_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ----- rtl/timestamped_position_interpolator_unit.sv -----
// ---------------------------------------------------------------------------
// timestamped_position_interpolator_unit
// Jitter buffer of timestamped positions with a playback clock and
// Q10.16 interpolation between the samples around the clock.
// ---------------------------------------------------------------------------
//
//   channel   handshake        word
//   input     start / busy     in_cmd, in_pos_x, in_pos_y, in_stamp, in_step_ticks
//   result    out_valid        out_x, out_y, out_play_time, out_fill, out_status
//   config    cfg_we           cfg_idx, cfg_wdata
//
// A command is taken when start is high and busy is low; exactly one result
// word follows as a one-cycle out_valid pulse, and busy drops in that cycle.
// Set clock, restart, clear, unknown codes, rejected and full pushes, and a
// push into an empty buffer report straight from idle. Any other push reads
// each entry it moves plus the one it stops at, with one read and one check
// per entry on the single buffer read port, then writes the new sample.
// An advance that reaches the next sample walks and compacts the buffer; with
// no span to interpolate it then ends, otherwise a bit-serial divide (49
// quotient bits) and three multiply and blend steps follow.
// Reset (synchronous, rst_n low) empties the buffer and sets the clock to
// -6; buffer RAM contents are not cleared. The receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module timestamped_position_interpolator_unit
  import tpi_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [2:0]          in_cmd,
  input  wire signed [31:0]  in_pos_x,
  input  wire signed [31:0]  in_pos_y,
  input  wire signed [31:0]  in_stamp,
  input  wire [15:0]         in_step_ticks,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_play_time,
  output logic [4:0]         out_fill,
  output logic [1:0]         out_status,
  input  wire                cfg_we,
  input  wire                cfg_idx,
  input  wire [15:0]         cfg_wdata
);

  `include "timestamped_position_interpolator_unit_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer and playback state.
  state_t             state_r, state_nxt;
  logic [15:0]        delay_r, delay_nxt;
  logic [15:0]        stale_r, stale_nxt;
  logic signed [31:0] clock_r, clock_nxt;
  logic signed [31:0] from_x_r, from_x_nxt, from_y_r, from_y_nxt;
  logic signed [31:0] from_tick_r, from_tick_nxt;
  logic signed [31:0] to_x_r, to_x_nxt, to_y_r, to_y_nxt;
  logic signed [31:0] to_tick_r, to_tick_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      wr_r, wr_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, st_r, st_nxt;
  logic signed [25:0] p_r, p_nxt;
  logic signed [58:0] prod_r, prod_nxt;
  logic signed [31:0] res_x_r, res_x_nxt;

  // Result word register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic signed [31:0] out_time_r, out_time_nxt;
  logic [4:0]         out_fill_r, out_fill_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  // Buffer RAM: {x, y, tick} per entry.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [95:0]        ram_wdata;
  logic [95:0]        ram_rdata;
  logic signed [31:0] rd_x, rd_y, rd_t;

  // Divider hookup.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;

  // Datapath helpers.
  logic signed [33:0] num_w;
  logic [32:0]        num_mag;
  logic signed [33:0] den_w;
  logic [24:0]        p_mag;
  logic signed [32:0] dx, dy, mul_a;
  logic signed [31:0] adv_clock;
  logic               stale_hit;
  logic [CW-1:0]      wr_inc;
  logic               fin;
  logic signed [31:0] fin_x, fin_y;
  logic [1:0]         fin_status;

  assign rd_x = ram_rdata[95:64];
  assign rd_y = ram_rdata[63:32];
  assign rd_t = ram_rdata[31:0];

  tpi_ram #(
    .WIDTH(96),
    .DEPTH(DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Progress = (clock - from_tick) * 65536 / (to_tick - from_tick), on
  // magnitudes; the sign is put back after the divide.
  assign num_w   = 34'(clock_r) - 34'(from_tick_r);
  assign num_mag = (num_w < 0) ? 33'(-num_w) : num_w[32:0];
  assign den_w   = 34'(to_tick_r) - 34'(from_tick_r);
  assign div_num = {num_mag, 16'd0};
  assign div_den = den_w[32:0];

  tpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign p_mag = (div_quo > P_CLAMP) ? P_CLAMP[24:0] : div_quo[24:0];

  assign dx    = 33'(to_x_r) - 33'(from_x_r);
  assign dy    = 33'(to_y_r) - 33'(from_y_r);
  assign mul_a = (state_r == S_MUL_X) ? dx : dy;

  assign adv_clock = sat32(44'(clock_r) + $signed({28'd0, in_step_ticks}));

  // A passed sample is stale when clock > tick + stale_ticks (no wrap).
  assign stale_hit = (34'(clock_r) > 34'(rd_t) + $signed({18'd0, stale_r}));
  assign wr_inc    = wr_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    delay_nxt     = delay_r;
    stale_nxt     = stale_r;
    clock_nxt     = clock_r;
    from_x_nxt    = from_x_r;
    from_y_nxt    = from_y_r;
    from_tick_nxt = from_tick_r;
    to_x_nxt      = to_x_r;
    to_y_nxt      = to_y_r;
    to_tick_nxt   = to_tick_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wr_nxt        = wr_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    st_nxt        = st_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    res_x_nxt     = res_x_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_r[AW-1:0];
    ram_wdata     = ram_rdata;
    div_start     = 1'b0;
    fin           = 1'b0;
    fin_x         = '0;
    fin_y         = '0;
    fin_status    = ST_OK;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DELAY: delay_nxt = cfg_wdata;
        CFG_STALE: stale_nxt = cfg_wdata;
        default:   delay_nxt = delay_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          px_nxt = in_pos_x;
          py_nxt = in_pos_y;
          st_nxt = in_stamp;
          unique case (in_cmd)
            CMD_PUSH: begin
              if (in_stamp < to_tick_r) begin
                fin        = 1'b1;
                fin_status = ST_REJECT;
              end else begin
                // A sample behind the clock pulls the clock back first.
                if (clock_r > in_stamp) begin
                  clock_nxt = sat32(44'(in_stamp) - $signed({28'd0, delay_r}));
                end
                if (count_r == CW'(DEPTH)) begin
                  fin        = 1'b1;
                  fin_status = ST_FULL;
                end else if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = {in_pos_x, in_pos_y, in_stamp};
                  count_nxt = CW'(1);
                  fin       = 1'b1;
                end else begin
                  // Walk down from the newest entry, shifting up as we go.
                  idx_nxt   = count_r - CW'(1);
                  state_nxt = S_INS_RD;
                end
              end
            end
            CMD_ADVANCE: begin
              clock_nxt = adv_clock;
              if (adv_clock >= to_tick_r) begin
                from_x_nxt    = to_x_r;
                from_y_nxt    = to_y_r;
                from_tick_nxt = to_tick_r;
                idx_nxt       = '0;
                wr_nxt        = '0;
                state_nxt     = (count_r == '0) ? S_INTERP : S_WALK_RD;
              end else begin
                state_nxt = S_INTERP;
              end
            end
            CMD_SET: begin
              clock_nxt = sat32(44'(in_stamp) - $signed({28'd0, delay_r}));
              fin       = 1'b1;
            end
            CMD_RESTART: begin
              clock_nxt     = $signed({16'd0, delay_r});
              from_x_nxt    = in_pos_x;
              from_y_nxt    = in_pos_y;
              from_tick_nxt = -$signed({16'd0, delay_r});
              to_x_nxt      = in_pos_x;
              to_y_nxt      = in_pos_y;
              to_tick_nxt   = -$signed({16'd0, delay_r});
              fin           = 1'b1;
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_INS_RD: state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        // Reads go downward and writes land one above, so no read ever
        // meets an entry written in the same pass.
        if (st_r < rd_t) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r + CW'(1));
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            wr_nxt    = '0;
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = idx_r - CW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          wr_nxt    = idx_r + CW'(1);
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = wr_r[AW-1:0];
        ram_wdata = {px_r, py_r, st_r};
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
      end
      S_WALK_RD: state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (clock_r >= rd_t) begin
          from_x_nxt    = rd_x;
          from_y_nxt    = rd_y;
          from_tick_nxt = rd_t;
          if (!stale_hit) begin
            ram_we    = 1'b1;
            ram_waddr = wr_r[AW-1:0];
            ram_wdata = ram_rdata;
            wr_nxt    = wr_inc;
          end
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(1) == count_r) begin
            count_nxt = stale_hit ? wr_r : wr_inc;
            state_nxt = S_INTERP;
          end else begin
            state_nxt = S_WALK_RD;
          end
        end else begin
          to_x_nxt    = rd_x;
          to_y_nxt    = rd_y;
          to_tick_nxt = rd_t;
          // Nothing dropped: the rest of the buffer is already in place.
          state_nxt   = (wr_r == idx_r) ? S_INTERP : S_COPY_RD;
        end
      end
      S_COPY_RD: state_nxt = S_COPY_CHK;
      S_COPY_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = wr_r[AW-1:0];
        ram_wdata = ram_rdata;
        wr_nxt    = wr_inc;
        idx_nxt   = idx_r + CW'(1);
        if (idx_r + CW'(1) == count_r) begin
          count_nxt = wr_inc;
          state_nxt = S_INTERP;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_INTERP: begin
        if (from_tick_r >= to_tick_r) begin
          fin   = 1'b1;
          fin_x = from_x_r;
          fin_y = from_y_r;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          p_nxt     = (num_w < 0) ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X: begin
        prod_nxt  = mul_a * p_r;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        res_x_nxt = blend_fn(from_x_r, prod_r);
        prod_nxt  = mul_a * p_r;
        state_nxt = S_BLEND_Y;
      end
      S_BLEND_Y: begin
        fin   = 1'b1;
        fin_x = res_x_r;
        fin_y = blend_fn(from_y_r, prod_r);
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end

    out_valid_nxt  = fin;
    out_x_nxt      = fin ? fin_x : out_x_r;
    out_y_nxt      = fin ? fin_y : out_y_r;
    out_time_nxt   = fin ? clock_nxt : out_time_r;
    out_fill_nxt   = fin ? 5'(count_nxt) : out_fill_r;
    out_status_nxt = fin ? fin_status : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      delay_r     <= DELAY_RST;
      stale_r     <= STALE_RST;
      clock_r     <= -$signed({16'd0, DELAY_RST});
      from_x_r    <= '0;
      from_y_r    <= '0;
      from_tick_r <= -$signed({16'd0, DELAY_RST});
      to_x_r      <= '0;
      to_y_r      <= '0;
      to_tick_r   <= -$signed({16'd0, DELAY_RST});
      count_r     <= '0;
      idx_r       <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      delay_r     <= delay_nxt;
      stale_r     <= stale_nxt;
      clock_r     <= clock_nxt;
      from_x_r    <= from_x_nxt;
      from_y_r    <= from_y_nxt;
      from_tick_r <= from_tick_nxt;
      to_x_r      <= to_x_nxt;
      to_y_r      <= to_y_nxt;
      to_tick_r   <= to_tick_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    st_r         <= st_nxt;
    p_r          <= p_nxt;
    prod_r       <= prod_nxt;
    res_x_r      <= res_x_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_time_r   <= out_time_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_play_time = out_time_r;
  assign out_fill      = out_fill_r;
  assign out_status    = out_status_r;

  // The fill count never passes the buffer depth.
  `TPI_ASSERT_IMP(a_fill_bound, 1'b1, count_r <= CW'(DEPTH))
  // An accepted command is either still at work or has just reported.
  `TPI_ASSERT_NXT(a_accept_progress, start && !busy, busy || out_valid)
  // A result word is only shown once the sequencer is back at rest.
  `TPI_ASSERT_IMP(a_result_idle, out_valid, !busy)
  // A full drop is only reported while the buffer really is full.
  `TPI_ASSERT_IMP(a_full_drop, out_valid && (out_status == ST_FULL), count_r == CW'(DEPTH))

endmodule

`default_nettype wire

// ----- bench/timestamped_position_interpolator_unit_checker.sv -----
// ---------------------------------------------------------------------------
// Position interpolator checker
// Watches commands, configuration writes and result words, keeps its own
// model of the jitter buffer and playback clock, and compares each result
// word field by field with the oldest predicted word.
// ---------------------------------------------------------------------------
`default_nettype none

module timestamped_position_interpolator_unit_checker
  import tpi_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire               busy,
  input  wire [2:0]         in_cmd,
  input  wire signed [31:0] in_pos_x,
  input  wire signed [31:0] in_pos_y,
  input  wire signed [31:0] in_stamp,
  input  wire [15:0]        in_step_ticks,
  input  wire               out_valid,
  input  wire signed [31:0] out_x,
  input  wire signed [31:0] out_y,
  input  wire signed [31:0] out_play_time,
  input  wire [4:0]         out_fill,
  input  wire [1:0]         out_status,
  input  wire               cfg_we,
  input  wire               cfg_idx,
  input  wire [15:0]        cfg_wdata,
  output int                errors,
  output int                pending,
  output int                words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] play;
    logic [4:0]         fill;
    logic [1:0]         status;
  } word_t;

  word_t expected_words[$];

  longint lag, stale_win;
  longint smp_x[DEPTH_DEF], smp_y[DEPTH_DEF], smp_t[DEPTH_DEF];
  int     n_smp;
  longint play_clk, fx, fy, ft, tx, ty, tt;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mix(longint a, longint b, longint p);
    return clamp32(a + ((b - a) * p) / 65536);
  endfunction

  task automatic model_reset();
    lag = DELAY_RST;
    stale_win = STALE_RST;
    n_smp = 0;
    play_clk = -lag;
    fx = 0; fy = 0; ft = -lag;
    tx = 0; ty = 0; tt = -lag;
  endtask

  // Moves past due samples, keeping those still inside the stale window.
  function automatic void pass_due_samples();
    int i, w;
    i = 0; w = 0;
    fx = tx; fy = ty; ft = tt;
    while (i < n_smp) begin
      if (play_clk >= smp_t[i]) begin
        fx = smp_x[i]; fy = smp_y[i]; ft = smp_t[i];
        if (!(play_clk > smp_t[i] + stale_win)) begin
          smp_x[w] = smp_x[i]; smp_y[w] = smp_y[i]; smp_t[w] = smp_t[i];
          w++;
        end
        i++;
      end else begin
        tx = smp_x[i]; ty = smp_y[i]; tt = smp_t[i];
        break;
      end
    end
    while (i < n_smp) begin
      smp_x[w] = smp_x[i]; smp_y[w] = smp_y[i]; smp_t[w] = smp_t[i];
      w++; i++;
    end
    n_smp = w;
  endfunction

  function automatic word_t predict_position(logic [2:0] cmd, longint px, longint py,
                                             longint st, longint dt);
    word_t  r;
    longint ox, oy, p;
    int     at;
    ox = 0; oy = 0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (st < tt) begin
          r.status = ST_REJECT;
        end else begin
          if (play_clk > st) play_clk = clamp32(st - lag);
          if (n_smp >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            at = n_smp;
            for (int k = 0; k < n_smp; k++) begin
              if (st < smp_t[k]) begin
                at = k;
                break;
              end
            end
            for (int k = n_smp; k > at; k--) begin
              smp_x[k] = smp_x[k-1]; smp_y[k] = smp_y[k-1]; smp_t[k] = smp_t[k-1];
            end
            smp_x[at] = px; smp_y[at] = py; smp_t[at] = st;
            n_smp++;
          end
        end
      end
      CMD_ADVANCE: begin
        play_clk = clamp32(play_clk + dt);
        if (play_clk >= tt) pass_due_samples();
        if (ft >= tt) begin
          ox = fx; oy = fy;
        end else begin
          p = ((play_clk - ft) * 65536) / (tt - ft);
          if (p > 64'sd16777216) p = 64'sd16777216;
          if (p < -64'sd16777216) p = -64'sd16777216;
          ox = mix(fx, tx, p);
          oy = mix(fy, ty, p);
        end
      end
      CMD_SET: play_clk = clamp32(st - lag);
      CMD_RESTART: begin
        play_clk = lag;
        fx = px; fy = py; ft = -lag;
        tx = px; ty = py; tt = -lag;
      end
      CMD_CLEAR: n_smp = 0;
      default: ;
    endcase
    r.x = ox[31:0];
    r.y = oy[31:0];
    r.play = play_clk[31:0];
    r.fill = n_smp[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  assign pending = expected_words.size();

  initial begin
    errors = 0;
    words_seen = 0;
    model_reset();
  end

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      model_reset();
      expected_words.delete();
    end else begin
      // A result word leaves in the cycle where busy drops, so it is
      // compared before a new command taken on the same edge is modeled.
      if (out_valid) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
          if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
          if (out_play_time !== w.play)
            report_mismatch("out_play_time", out_play_time, w.play);
          if (out_fill !== w.fill) report_mismatch("out_fill", out_fill, w.fill);
          if (out_status !== w.status)
            report_mismatch("out_status", out_status, w.status);
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_DELAY) lag = cfg_wdata;
        else stale_win = cfg_wdata;
      end
      if (start && !busy)
        expected_words = {expected_words,
                          predict_position(in_cmd, in_pos_x, in_pos_y,
                                           in_stamp, in_step_ticks)};
    end
  end
endmodule

`default_nettype wire

// ----- bench/timestamped_position_interpolator_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Position interpolator testbench
// Drives commands and configuration writes into the interpolator and lets
// the checker predict and compare every result word; a short directed run
// is followed by random streams of all commands, mostly pushes and advances.
// ---------------------------------------------------------------------------
`default_nettype none

module timestamped_position_interpolator_unit_tb
  import tpi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_cmd;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_stamp;
  logic [15:0]        in_step_ticks;
  logic               out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_play_time;
  logic [4:0]         out_fill;
  logic [1:0]         out_status;
  logic               cfg_we;
  logic               cfg_idx;
  logic [15:0]        cfg_wdata;

  int errors, pending, words_seen;
  int quiet_cycles;
  int cmds_sent;
  bit calm_stretch;

  // The stream of pushes walks forward in ticks from this point.
  int stream_tick;

  timestamped_position_interpolator_unit dut (.*);

  timestamped_position_interpolator_unit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which neither a command nor a result
  // word moves; a stuck block ends the run as a failure.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Sends one command word: it is held until taken at a rising edge with
  // busy low, then start is dropped at the next falling edge unless the
  // caller follows with another word straight away.
  task automatic send_word(logic [2:0] cmd, logic [31:0] px, logic [31:0] py,
                           logic [31:0] st, logic [15:0] dt);
    if (!calm_stretch && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_stamp      <= st;
    in_step_ticks <= dt;
    do @(posedge clk); while (busy);
    @(negedge clk);
    cmds_sent++;
  endtask

  // Configuration changes only while no result word is outstanding; the
  // extra wait covers the final cycle of the last command.
  task automatic write_reg(logic idx, logic [15:0] val);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_stream(int count);
    logic [2:0] cmd;
    int r;
    for (int i = 0; i < count; i++) begin
      calm_stretch = (i >= count / 3) && (i < count / 2);
      r = $urandom_range(99);
      if (r < 45) begin
        // Mostly in-order samples with some jitter, sometimes far off.
        stream_tick += $urandom_range(0, 8);
        if ($urandom_range(9) == 0)
          send_word(CMD_PUSH, $urandom, $urandom, $urandom, $urandom);
        else
          send_word(CMD_PUSH, $urandom, $urandom,
                    stream_tick - $urandom_range(0, 6), $urandom);
      end else if (r < 85) begin
        send_word(CMD_ADVANCE, $urandom, $urandom, $urandom,
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
      end else if (r < 90) begin
        send_word(CMD_SET, $urandom, $urandom,
                  ($urandom_range(3) == 0) ? $urandom : stream_tick, $urandom);
      end else if (r < 94) begin
        send_word(CMD_RESTART, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 97) begin
        send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else begin
        cmd = 3'($urandom_range(5, 7));
        send_word(cmd, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    start         = 1'b0;
    in_cmd        = CMD_CLEAR;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_stamp      = '0;
    in_step_ticks = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_DELAY;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    quiet_cycles  = 0;
    cmds_sent     = 0;
    calm_stretch  = 1'b0;
    stream_tick   = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset settings: interpolation between two
    // samples, a too-old push, a full buffer, restart, clear, the unknown
    // codes, and saturation of the clock at both ends.
    send_word(CMD_PUSH, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sd10, 16'd0);
    send_word(CMD_PUSH, 32'sh8000_0000, 32'sh0000_0000, 32'sd20, 16'hFFFF);
    send_word(CMD_ADVANCE, '0, '0, '0, 16'd15);
    send_word(CMD_ADVANCE, '0, '0, '0, 16'd4);
    send_word(CMD_PUSH, 32'sd5, 32'sd5, -32'sd100, 16'd0);
    for (int i = 0; i < 17; i++)
      send_word(CMD_PUSH, i * 32'sd4096, -i * 32'sd4096, 32'sd30 + i % 5, 16'd0);
    send_word(CMD_ADVANCE, '0, '0, '0, 16'hFFFF);
    send_word(CMD_RESTART, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 16'd0);
    send_word(CMD_SET, '0, '0, 32'sh7FFF_FFFF, 16'd0);
    send_word(CMD_ADVANCE, '0, '0, '0, 16'hFFFF);
    send_word(CMD_SET, '0, '0, 32'sh8000_0000, 16'd0);
    send_word(CMD_CLEAR, '0, '0, '0, 16'd0);
    for (int c = 5; c <= 7; c++)
      send_word(3'(c), '1, '1, '1, '1);

    // Random phases across several register settings, extremes included.
    random_stream(150);
    write_reg(CFG_DELAY, 16'd0);
    write_reg(CFG_STALE, 16'd0);
    send_word(CMD_RESTART, '0, '0, '0, 16'd0);
    stream_tick = 0;
    random_stream(150);
    write_reg(CFG_DELAY, 16'hFFFF);
    write_reg(CFG_STALE, 16'hFFFF);
    send_word(CMD_RESTART, $urandom, $urandom, '0, 16'd0);
    stream_tick = 0;
    random_stream(150);
    write_reg(CFG_DELAY, 16'd3);
    write_reg(CFG_STALE, 16'd12);
    send_word(CMD_SET, '0, '0, 32'sh8000_0010, 16'd0);
    send_word(CMD_RESTART, '0, '0, '0, 16'd0);
    stream_tick = 0;
    random_stream(150);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Sent %0d command words and checked %0d result words over four",
             cmds_sent, words_seen);
    $display("register settings, covering pushes, advances, restarts and clears.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
